FILE: rtl/core/cmap_glyph_index_lookup_core_macros.svh
// assertion macros for the cmap glyph lookup core
// used by the top level; needs nothing else
`ifndef CMAP_GLYPH_INDEX_LOOKUP_CORE_MACROS_SVH
`define CMAP_GLYPH_INDEX_LOOKUP_CORE_MACROS_SVH

// same-cycle implication
`define CGIL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CGIL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cgil_pkg.sv
// shared constants for the cmap glyph lookup core
// no dependencies
package cgil_pkg;

  localparam int STORE_BYTES_DEF = 65536;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int BASE_W     = 16;
  localparam int LEN_W      = 17;
  localparam int OFF_W      = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FMT4_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FMT4_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FMT12_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FMT12_LENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FMT13_BASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FMT13_LENGTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_MODE  = 3'd6;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // byte counts of a fetch
  localparam logic [2:0] FETCH_2 = 3'd2;
  localparam logic [2:0] FETCH_4 = 3'd4;

endpackage

FILE: rtl/core/cgil_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module cgil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/cmap_glyph_index_lookup_core.sv
// cmap glyph lookup core: byte store of cmap subtables and the lookup sequencer
// depends on cgil_pkg, cgil_ram and cmap_glyph_index_lookup_core_macros.svh
//
// usage:
// - in channel: operation 0 writes store_byte at store_address (no result
//   word); operation 1 looks up char_code and yields one result word with
//   glyph_id and map_present
// - cfg channel: cfg_index selects fmt4/12/13 base and length and symbol mode;
//   always ready, write only while no lookup is in flight
// - store bytes are read one per cycle through the single ram read port
// - format 12/13: setup, then a binary search with one probe per step and
//   a glyph fetch on a hit; format 4: setup, a scan of segments, then the
//   map; a symbol retry runs the search again
// - a lookup with no subtable configured goes straight to output, map_present low
// - the result sits in an output register; a stalled receiver holds the
//   sequencer at the end of a lookup, and byte writes are not taken meanwhile
// - reset clears registers and control; store contents are undefined until
//   written
module cmap_glyph_index_lookup_core
  import cgil_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [15:0]           in_store_address,
  input  logic [7:0]            in_store_byte,
  input  logic [31:0]           in_char_code,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_glyph_id,
  output logic                  out_map_present,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int AXW = (AW > 21) ? AW : 21;
  localparam int WXW = (AW > 16) ? AW : 16;

  typedef enum logic [4:0] {
    S_IDLE, S_SEL, S_FETCH, S_G_LEN, S_G_CNT, S_G_MID, S_G_S, S_G_E, S_G_GLY,
    S_G_END, S_4_LEN, S_4_SEG, S_4_SCAN, S_4_END, S_4_ST, S_4_DL, S_4_RG,
    S_4_GLY, S_RES, S_OUT
  } state_t;

  typedef enum logic [1:0] {F12, F13, F4} fmt_t;

  state_t state_r, ret_r;
  fmt_t   fmt_r;

  logic [BASE_W-1:0] fmt4_base_r, fmt12_base_r, fmt13_base_r;
  logic [LEN_W-1:0]  fmt4_length_r, fmt12_length_r, fmt13_length_r;
  logic              symbol_mode_r;

  logic [2:0]        fk_r, fn_r;
  logic [OFF_W-1:0]  foff_r;
  logic [31:0]       acc_r;
  logic              inr_r;
  logic [BASE_W-1:0] base_r;
  logic [LEN_W-1:0]  len_r;
  logic              cnst_r;
  logic [31:0]       cp_r;
  logic              symok_r, pass_r, pres_r;
  logic [16:0]       lo_r, hi_r, mid_r;
  logic [31:0]       s_r;
  logic [15:0]       g_r;
  logic              ok_r;
  logic [14:0]       segs_r, seg_r;
  logic [15:0]       start_r, delta_r;
  logic              out_valid_r, out_present_r;
  logic [15:0]       out_glyph_r;

  logic [AXW-1:0]    faddr;
  logic              faddr_ok;
  logic [7:0]        ram_rdata;
  logic [WXW-1:0]    wext;
  logic              wr_en;
  logic              has4, has_any;
  logic [16:0]       mid_c;
  logic [OFF_W-1:0]  goff;
  logic [20:0]       cnt12, lim12;
  logic [32:0]       sum33;
  logic [31:0]       gsel;
  logic [14:0]       segs_c;
  logic [OFF_W-1:0]  rng_c, ranges, starts, deltas, seg2, addr4;

  assign has4    = fmt4_length_r != '0;
  assign has_any = has4 || fmt12_length_r != '0 || fmt13_length_r != '0;

  assign in_ready  = state_r == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_glyph_id    = out_glyph_r;
  assign out_map_present = out_present_r;

  // store writes, out-of-range addresses dropped
  assign wext  = WXW'(in_store_address);
  assign wr_en = in_valid && in_ready && in_operation == OP_WRITE &&
                 26'(in_store_address) < 26'(STORE_BYTES);

  assign faddr    = AXW'(base_r) + AXW'(foff_r) + AXW'(fk_r);
  assign faddr_ok = 26'(faddr) < 26'(STORE_BYTES);

  cgil_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wext[AW-1:0]),
    .wdata (in_store_byte),
    .raddr (faddr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    mid_c  = 17'((18'(lo_r) + 18'(hi_r)) >> 1);
    goff   = 20'd16 + 20'(mid_r) * 20'd12;
    cnt12  = 21'(acc_r[16:0]) * 21'd12;
    lim12  = 21'(len_r) - 21'd16;
    sum33  = 33'(acc_r) + 33'(cp_r - s_r);
    gsel   = cnst_r ? acc_r : sum33[31:0];
    segs_c = acc_r[15:1];
    rng_c  = 20'd16 + 20'(segs_c) * 20'd6;
    ranges = 20'd16 + 20'(segs_r) * 20'd6;
    starts = 20'd16 + 20'(segs_r) * 20'd2;
    deltas = 20'd16 + 20'(segs_r) * 20'd4;
    seg2   = 20'(seg_r) * 20'd2;
    addr4  = ranges + seg2 + 20'(acc_r[15:0]) +
             (20'(16'(cp_r[15:0] - start_r)) << 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      fmt4_base_r    <= '0;
      fmt4_length_r  <= '0;
      fmt12_base_r   <= '0;
      fmt12_length_r <= '0;
      fmt13_base_r   <= '0;
      fmt13_length_r <= '0;
      symbol_mode_r  <= 1'b0;
      pass_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FMT4_BASE:    fmt4_base_r    <= cfg_data[BASE_W-1:0];
          REG_FMT4_LENGTH:  fmt4_length_r  <= cfg_data;
          REG_FMT12_BASE:   fmt12_base_r   <= cfg_data[BASE_W-1:0];
          REG_FMT12_LENGTH: fmt12_length_r <= cfg_data;
          REG_FMT13_BASE:   fmt13_base_r   <= cfg_data[BASE_W-1:0];
          REG_FMT13_LENGTH: fmt13_length_r <= cfg_data;
          REG_SYMBOL_MODE:  symbol_mode_r  <= cfg_data[0];
          default: ;
        endcase
      end
      // S_OUT loads the next word itself
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready && in_operation == OP_LOOKUP) begin
            cp_r    <= in_char_code;
            symok_r <= in_char_code <= 32'hFF;
            pass_r  <= 1'b0;
            fmt_r   <= F12;
            g_r     <= '0;
            pres_r  <= has_any;
            state_r <= has_any ? S_SEL : S_OUT;
          end
        end
        S_SEL: begin
          unique case (fmt_r)
            F12: begin
              if (fmt12_length_r != '0) begin
                base_r <= fmt12_base_r; len_r <= fmt12_length_r;
                cnst_r <= 1'b0; state_r <= S_G_LEN;
              end else begin
                fmt_r <= F13;
              end
            end
            F13: begin
              if (fmt13_length_r != '0) begin
                base_r <= fmt13_base_r; len_r <= fmt13_length_r;
                cnst_r <= 1'b1; state_r <= S_G_LEN;
              end else begin
                fmt_r <= F4;
              end
            end
            default: begin
              if (has4) begin
                base_r <= fmt4_base_r; len_r <= fmt4_length_r;
                state_r <= S_4_LEN;
              end else begin
                g_r <= '0; state_r <= S_RES;
              end
            end
          endcase
        end
        // byte-serial read of fn_r bytes, big-endian into acc_r
        S_FETCH: begin
          inr_r <= faddr_ok;
          if (fk_r != '0) begin
            acc_r <= {acc_r[23:0], inr_r ? ram_rdata : 8'h00};
          end
          if (fk_r == fn_r) begin
            state_r <= ret_r;
          end else begin
            fk_r <= fk_r + 3'd1;
          end
        end
        S_G_LEN: begin
          if (len_r < 17'd16) begin
            ok_r <= 1'b0; g_r <= '0; state_r <= S_G_END;
          end else begin
            foff_r <= 20'd12; fk_r <= '0; fn_r <= FETCH_4;
            ret_r <= S_G_CNT; state_r <= S_FETCH;
          end
        end
        S_G_CNT: begin
          if (acc_r[31:17] != '0 || cnt12 > lim12) begin
            ok_r <= 1'b0; g_r <= '0; state_r <= S_G_END;
          end else begin
            lo_r <= '0; hi_r <= acc_r[16:0]; state_r <= S_G_MID;
          end
        end
        S_G_MID: begin
          if (lo_r >= hi_r) begin
            ok_r <= 1'b1; g_r <= '0; state_r <= S_G_END;
          end else begin
            mid_r  <= mid_c;
            foff_r <= 20'd16 + 20'(mid_c) * 20'd12;
            fk_r <= '0; fn_r <= FETCH_4; ret_r <= S_G_S; state_r <= S_FETCH;
          end
        end
        S_G_S: begin
          s_r    <= acc_r;
          foff_r <= goff + 20'd4;
          fk_r <= '0; fn_r <= FETCH_4; ret_r <= S_G_E; state_r <= S_FETCH;
        end
        S_G_E: begin
          if (cp_r < s_r) begin
            hi_r <= mid_r; state_r <= S_G_MID;
          end else if (cp_r > acc_r) begin
            lo_r <= mid_r + 17'd1; state_r <= S_G_MID;
          end else begin
            foff_r <= goff + 20'd8;
            fk_r <= '0; fn_r <= FETCH_4; ret_r <= S_G_GLY; state_r <= S_FETCH;
          end
        end
        S_G_GLY: begin
          if (!cnst_r && sum33[32]) begin
            ok_r <= 1'b0; g_r <= '0;
          end else begin
            ok_r <= 1'b1;
            g_r  <= (gsel[31:16] == '0) ? gsel[15:0] : 16'h0000;
          end
          state_r <= S_G_END;
        end
        // zero falls through to the next format only when format 4 exists; a bad subtable always does
        S_G_END: begin
          if (ok_r && (g_r != '0 || !has4)) begin
            state_r <= S_RES;
          end else begin
            fmt_r   <= cnst_r ? F4 : F13;
            state_r <= S_SEL;
          end
        end
        S_4_LEN: begin
          if (len_r < 17'd14 || cp_r[31:16] != '0) begin
            g_r <= '0; state_r <= S_RES;
          end else begin
            foff_r <= 20'd6; fk_r <= '0; fn_r <= FETCH_2;
            ret_r <= S_4_SEG; state_r <= S_FETCH;
          end
        end
        S_4_SEG: begin
          if (segs_c == '0 || rng_c > 20'(len_r) ||
              20'(segs_c) * 20'd2 > 20'(len_r) - rng_c) begin
            g_r <= '0; state_r <= S_RES;
          end else begin
            segs_r <= segs_c; seg_r <= '0; state_r <= S_4_SCAN;
          end
        end
        S_4_SCAN: begin
          if (seg_r == segs_r) begin
            g_r <= '0; state_r <= S_RES;
          end else begin
            foff_r <= 20'd14 + seg2;
            fk_r <= '0; fn_r <= FETCH_2; ret_r <= S_4_END; state_r <= S_FETCH;
          end
        end
        S_4_END: begin
          if (32'(acc_r[15:0]) < cp_r) begin
            seg_r <= seg_r + 15'd1; state_r <= S_4_SCAN;
          end else begin
            foff_r <= starts + seg2;
            fk_r <= '0; fn_r <= FETCH_2; ret_r <= S_4_ST; state_r <= S_FETCH;
          end
        end
        S_4_ST: begin
          if (32'(acc_r[15:0]) > cp_r) begin
            g_r <= '0; state_r <= S_RES;
          end else begin
            start_r <= acc_r[15:0];
            foff_r  <= deltas + seg2;
            fk_r <= '0; fn_r <= FETCH_2; ret_r <= S_4_DL; state_r <= S_FETCH;
          end
        end
        S_4_DL: begin
          delta_r <= acc_r[15:0];
          foff_r  <= ranges + seg2;
          fk_r <= '0; fn_r <= FETCH_2; ret_r <= S_4_RG; state_r <= S_FETCH;
        end
        S_4_RG: begin
          if (acc_r[15:0] == '0) begin
            g_r <= cp_r[15:0] + delta_r; state_r <= S_RES;
          end else if (21'(addr4) + 21'd2 > 21'(len_r)) begin
            g_r <= '0; state_r <= S_RES;
          end else begin
            foff_r <= addr4;
            fk_r <= '0; fn_r <= FETCH_2; ret_r <= S_4_GLY; state_r <= S_FETCH;
          end
        end
        S_4_GLY: begin
          g_r     <= (acc_r[15:0] == '0) ? 16'h0000 : acc_r[15:0] + delta_r;
          state_r <= S_RES;
        end
        // symbol fonts: retry once at 0xf000 plus the code
        S_RES: begin
          if (g_r == '0 && symbol_mode_r && symok_r && !pass_r) begin
            pass_r  <= 1'b1;
            cp_r    <= cp_r + 32'hF000;
            fmt_r   <= F12;
            state_r <= S_SEL;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_glyph_r   <= g_r;
            out_present_r <= pres_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "cmap_glyph_index_lookup_core_macros.svh"

  `CGIL_ASSERT_NXT(a_lookup_busy, clk, rst_n,
    in_valid && in_ready && in_operation == OP_LOOKUP, !in_ready,
    "lookup word did not start the sequencer")
  `CGIL_ASSERT_NXT(a_write_idle, clk, rst_n,
    in_valid && in_ready && in_operation == OP_WRITE, in_ready,
    "store write left the idle state")
  `CGIL_ASSERT_IMP(a_absent_zero, clk, rst_n,
    out_valid && !out_map_present, out_glyph_id == 16'h0000,
    "no map present but glyph not zero")
  `CGIL_ASSERT_IMP(a_fetch_bound, clk, rst_n,
    state_r == S_FETCH, fk_r <= fn_r && (fn_r == FETCH_2 || fn_r == FETCH_4),
    "fetch counter out of range")

endmodule
